// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the lockout table modules.
// Each macro expects aclk and aresetn to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define FRLT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FRLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/frlt_pkg.sv -----
package frlt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [COUNT_W-1:0] FAILURE_LIMIT_RESET   = 8'd5;
    localparam logic [TIME_W-1:0]  WINDOW_SECONDS_RESET  = 32'd600;
    localparam logic [TIME_W-1:0]  LOCKOUT_SECONDS_RESET = 32'd1800;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAILURE_LIMIT   = 2'd0,
        REG_WINDOW_SECONDS  = 2'd1,
        REG_LOCKOUT_SECONDS = 2'd2
    } cfg_reg_t;

    typedef enum logic [0:0] {
        REQ_CHECK   = 1'b0,
        REQ_FAILURE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key_high;
        logic [KEY_W-1:0]   key_low;
        logic [COUNT_W-1:0] fail_count;
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  last_failure;
        logic [TIME_W-1:0]  lock_end;
        logic               lock_valid;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_issue;
        logic calc;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic table_empty;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- sv/frlt_ram.sv -----
module frlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/frlt_ctrl.sv -----
`include "assert_macros.svh"

module frlt_ctrl
    import frlt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // No transfer is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = sts.table_empty ? ST_CALC : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // The read of the last slot returns during this cycle.
            ST_DRAIN: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FRLT_ASSERT_NEXT(a_accept_starts_work, s_tvalid && s_tready,
        state_reg == ST_SCAN || state_reg == ST_CALC, "transfer did not start a lookup")
    `FRLT_ASSERT_NEXT(a_scan_ends_in_drain, state_reg == ST_SCAN && sts.scan_last,
        state_reg == ST_DRAIN, "scan did not stop at the last used slot")
    `FRLT_ASSERT_NEXT(a_commit_returns_idle, cmd.commit,
        state_reg == ST_IDLE, "commit did not return to idle")

endmodule

// ----- sv/frlt_datapath.sv -----
`include "assert_macros.svh"

module frlt_datapath
    import frlt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  req_type,
    input  logic [KEY_W-1:0]      key_high,
    input  logic [KEY_W-1:0]      key_low,
    input  logic [TIME_W-1:0]     now_seconds,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  is_locked
);

    logic [COUNT_W-1:0] failure_limit_reg;
    logic [TIME_W-1:0]  window_seconds_reg;
    logic [TIME_W-1:0]  lockout_seconds_reg;

    logic               req_type_reg;
    logic [KEY_W-1:0]   key_high_reg;
    logic [KEY_W-1:0]   key_low_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [USED_W-1:0]  entries_used_reg;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_addr_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    entry_t             hit_entry_reg;
    logic [TIME_W-1:0]  best_age_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    logic               window_over_reg;
    logic               lock_active_reg;

    logic               m_tvalid_reg;
    logic               m_locked_reg;

    logic [ENTRY_W-1:0] rd_data;
    entry_t             rd_entry;
    logic               key_match;
    logic [TIME_W-1:0]  rd_age;
    logic [USED_W-1:0]  last_used;
    logic               table_full;

    entry_t             wr_entry;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               locked;
    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] new_count;
    logic [TIME_W-1:0]  lock_until;

    assign rd_entry   = entry_t'(rd_data);
    assign key_match  = (rd_entry.key_high == key_high_reg) && (rd_entry.key_low == key_low_reg);
    assign rd_age     = now_reg - rd_entry.last_failure;
    assign last_used  = entries_used_reg - USED_W'(1);
    assign table_full = (entries_used_reg == USED_W'(TABLE_DEPTH));

    assign sts.table_empty = (entries_used_reg == '0);
    assign sts.scan_last   = (scan_addr_reg == last_used[IDX_W-1:0]);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failure_limit_reg   <= FAILURE_LIMIT_RESET;
            window_seconds_reg  <= WINDOW_SECONDS_RESET;
            lockout_seconds_reg <= LOCKOUT_SECONDS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FAILURE_LIMIT:   failure_limit_reg   <= cfg_wdata[COUNT_W-1:0];
                REG_WINDOW_SECONDS:  window_seconds_reg  <= cfg_wdata[TIME_W-1:0];
                REG_LOCKOUT_SECONDS: lockout_seconds_reg <= cfg_wdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request capture, the table scan, the window and lock checks and the result capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= req_type;
            key_high_reg <= key_high;
            key_low_reg  <= key_low;
            now_reg      <= now_seconds;
        end
        rd_addr_reg <= scan_addr_reg;
        if (rd_valid_reg) begin
            if (key_match && !hit_reg) begin
                hit_idx_reg   <= rd_addr_reg;
                hit_entry_reg <= rd_entry;
            end
            // Strictly older wins, so ties keep the lowest slot.
            if (rd_addr_reg == '0 || rd_age > best_age_reg) begin
                best_age_reg <= rd_age;
                best_idx_reg <= rd_addr_reg;
            end
        end
        if (cmd.calc) begin
            window_over_reg <= (now_reg - hit_entry_reg.window_start) > window_seconds_reg;
            lock_active_reg <= hit_entry_reg.lock_valid &&
                ((now_reg - hit_entry_reg.last_failure) <
                 (hit_entry_reg.lock_end - hit_entry_reg.last_failure));
        end
        if (cmd.commit) begin
            m_locked_reg <= locked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_used_reg <= '0;
            scan_addr_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            hit_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.load) begin
                scan_addr_reg <= '0;
                hit_reg       <= 1'b0;
            end else if (cmd.scan_issue) begin
                scan_addr_reg <= scan_addr_reg + IDX_W'(1);
            end
            if (rd_valid_reg && key_match) begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit && req_type_reg == REQ_FAILURE && !hit_reg && !table_full) begin
                entries_used_reg <= entries_used_reg + USED_W'(1);
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Entry update for the committing request.
    assign base_count = (!hit_reg || window_over_reg) ? '0 : hit_entry_reg.fail_count;
    assign new_count  = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + COUNT_W'(1);
    assign lock_until = now_reg + lockout_seconds_reg;

    always_comb begin
        wr_entry = hit_entry_reg;
        wr_en    = 1'b0;
        wr_addr  = hit_idx_reg;
        locked   = 1'b0;
        if (req_type_reg == REQ_CHECK) begin
            if (hit_reg && hit_entry_reg.lock_valid) begin
                if (lock_active_reg) begin
                    locked = 1'b1;
                end else begin
                    wr_en               = cmd.commit;
                    wr_entry.fail_count = '0;
                    wr_entry.lock_valid = 1'b0;
                    wr_entry.lock_end   = '0;
                end
            end
        end else begin
            wr_en = cmd.commit;
            if (!hit_reg) begin
                wr_addr               = table_full ? best_idx_reg
                                                   : entries_used_reg[IDX_W-1:0];
                wr_entry.key_high     = key_high_reg;
                wr_entry.key_low      = key_low_reg;
                wr_entry.window_start = now_reg;
                wr_entry.lock_end     = '0;
                wr_entry.lock_valid   = 1'b0;
            end else if (window_over_reg) begin
                wr_entry.window_start = now_reg;
            end
            wr_entry.fail_count   = new_count;
            wr_entry.last_failure = now_reg;
            if (new_count >= failure_limit_reg) begin
                wr_entry.lock_end   = lock_until;
                wr_entry.lock_valid = 1'b1;
                locked              = 1'b1;
            end
        end
    end

    frlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    assign m_tvalid  = m_tvalid_reg;
    assign is_locked = m_locked_reg;

    `FRLT_ASSERT_ALWAYS(a_used_in_range, entries_used_reg <= USED_W'(TABLE_DEPTH),
        "slot count exceeds table depth")
    `FRLT_ASSERT_NEXT(a_commit_shows_result, cmd.commit,
        m_tvalid_reg, "committed request produced no result")

endmodule

// ----- sv/failure_rate_lockout_table.sv -----
// Channel    Ports                        Contents (lowest bit first)
// input      s_tvalid/s_tready/s_tdata    key_high[63:0], key_low[127:64], now_seconds[159:128]
//            s_tuser                      req_type (0 check, 1 failure)
// result     m_tvalid/m_tready/m_tdata    is_locked[0], zero fill [7:1]
// config     cfg_wr_en/cfg_index/cfg_wdata  failure_limit, window_seconds, lockout_seconds
//
// A request reads each of the N slots in use (1 to 64) before its result is offered; with
// an empty table it goes straight to the update step. The scan reads one table slot per
// cycle through the single read port of the table memory.
// Reset is synchronous and active low; it empties the table and loads the default
// configuration, no clearing pass is needed, and s_tready stays low while it is held.
// A result that is not taken holds the following request in its final step, and no
// further request is transferred until that result has gone.
module failure_rate_lockout_table_core
    import frlt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [159:0]          s_tdata,  // key_high, key_low, now_seconds
    input  logic [0:0]            s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // is_locked, zero fill
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      is_locked;

    frlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frlt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req_type    (s_tuser[0]),
        .key_high    (s_tdata[63:0]),
        .key_low     (s_tdata[127:64]),
        .now_seconds (s_tdata[159:128]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .is_locked   (is_locked)
    );

    assign m_tdata = {7'b0, is_locked};

endmodule
